@@ hw/rtl/pcar_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pcar_pkg;

  // Cache geometry.
  localparam int unsigned SlotCount = 64;
  localparam int unsigned SlotW     = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned CntW      = $clog2(SlotCount + 1);

  // Priority given to a freshly used slot, and the tag of a slot never written.
  localparam logic [7:0] PriFresh = 8'h80;
  localparam logic [7:0] TagReset = 8'hff;

  // Access kinds reported with each result.
  localparam logic [1:0] KindSame = 2'd0;
  localparam logic [1:0] KindHit  = 2'd1;
  localparam logic [1:0] KindMiss = 2'd2;

  typedef logic [SlotW-1:0] slot_t;

  // One slot as read from the store.
  typedef struct packed {
    logic [7:0] tag;
    logic [7:0] pri;
  } entry_t;

  // Write request into the slot store.
  typedef struct packed {
    logic       en;
    slot_t      addr;
    logic [7:0] tag;
    logic [7:0] pri;
  } wr_req_t;

  // Verdict of the compare unit on one slot.
  typedef struct packed {
    logic       hit;
    logic       empty;
    logic       age_write;
    logic [7:0] aged_pri;
    logic [7:0] hit_pri;
    logic       better;
  } verdict_t;

endpackage

`default_nettype wire

@@ hw/rtl/pcar_slot_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pcar_slot_store import pcar_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire slot_t   rd_addr_i,
  output entry_t       rd_entry_o,
  input  wire wr_req_t wr_req_i
);

  logic [15:0]          mem_q [SlotCount];
  logic [SlotCount-1:0] valid_q;
  logic [15:0]          rd_data_q;
  logic                 rd_valid_q;

  // Tag and priority storage, one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) begin
      mem_q[wr_req_i.addr] <= {wr_req_i.tag, wr_req_i.pri};
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // Written-slot flags; a slot never written reads as its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_req_i.en) begin
        valid_q[wr_req_i.addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_entry_o.tag = rd_valid_q ? rd_data_q[15:8] : TagReset;
  assign rd_entry_o.pri = rd_valid_q ? rd_data_q[7:0]  : 8'h00;

endmodule

`default_nettype wire

@@ hw/rtl/pcar_compare_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pcar_compare_unit import pcar_pkg::*; (
  input  wire entry_t     entry_i,
  input  wire logic [7:0] page_i,
  input  wire logic [8:0] best_pri_i,
  output verdict_t        verdict_o
);

  // Tag match, ageing and victim comparison for the slot under test.
  always_comb begin
    verdict_o.empty     = (entry_i.pri == 8'h00);
    verdict_o.hit       = !verdict_o.empty && (entry_i.tag == page_i);
    verdict_o.age_write = (entry_i.pri > 8'h01);
    verdict_o.aged_pri  = verdict_o.age_write ? {1'b0, entry_i.pri[7:1]} : entry_i.pri;
    verdict_o.hit_pri   = entry_i.pri | PriFresh;
    verdict_o.better    = ({1'b0, verdict_o.aged_pri} < best_pri_i);
  end

endmodule

`default_nettype wire

@@ hw/rtl/page_cache_aging_replacement_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// request   in_valid_i / in_stall_o    byte_address_i
// result    out_valid_o / out_stall_i  access_kind_o, slot_index_o, byte_offset_o,
//                                      evicted_valid_o, evicted_page_o
//
// Same-page requests go straight to the result, hits end the tag search early
// and misses follow it with the ageing pass and a fill: the tag search and the
// ageing pass each walk the slot store one slot a cycle through one compare unit.
// Reset leaves the cache empty and the last-page register invalid at once.
// A request is taken while an earlier result still waits in the output register.

module page_cache_aging_replacement_core import pcar_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] byte_address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       access_kind_o,
  output logic [5:0]       slot_index_o,
  output logic [7:0]       byte_offset_o,
  output logic             evicted_valid_o,
  output logic [7:0]       evicted_page_o
);

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StAge,
    StFill,
    StEmit
  } state_e;

  state_e            state_q;
  logic [7:0]        page_q;
  logic [7:0]        offset_q;
  logic [CntW-1:0]   cnt_q;
  logic              rd_pend_q;
  slot_t             rd_idx_q;
  logic [8:0]        best_pri_q;
  logic [7:0]        best_tag_q;
  slot_t             victim_q;
  logic              empty_found_q;
  logic [1:0]        res_kind_q;
  slot_t             res_slot_q;
  logic              res_ev_valid_q;
  logic [7:0]        res_ev_page_q;
  logic [7:0]        last_page_q;
  logic              last_valid_q;
  slot_t             last_slot_q;
  logic              out_valid_q;
  logic [1:0]        out_kind_q;
  logic [5:0]        out_slot_q;
  logic [7:0]        out_offset_q;
  logic              out_ev_valid_q;
  logic [7:0]        out_ev_page_q;

  slot_t             rd_addr;
  entry_t            rd_entry;
  wr_req_t           wr_req;
  verdict_t          verdict;
  logic              issue;
  logic              last_idx;
  logic              out_free;
  logic [SlotW+5:0]  slot_ext;

  pcar_slot_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .wr_req_i   (wr_req)
  );

  pcar_compare_unit u_compare (
    .entry_i    (rd_entry),
    .page_i     (page_q),
    .best_pri_i (best_pri_q),
    .verdict_o  (verdict)
  );

  // Read issue during the walks; the registered data returns in the following cycle.
  assign rd_addr  = cnt_q[SlotW-1:0];
  assign issue    = (cnt_q < CntW'(SlotCount));
  assign last_idx = (rd_idx_q == slot_t'(SlotCount - 1));
  assign out_free = !out_valid_q || !out_stall_i;
  assign slot_ext = {6'b0, res_slot_q};

  // Store writes: priority refresh on a hit, ageing, and the fill on a miss.
  always_comb begin
    wr_req      = '0;
    wr_req.addr = rd_idx_q;
    wr_req.tag  = rd_entry.tag;
    wr_req.pri  = verdict.aged_pri;
    case (state_q)
      StSearch: begin
        if (rd_pend_q && verdict.hit) begin
          wr_req.en  = 1'b1;
          wr_req.pri = verdict.hit_pri;
        end
      end
      StAge: begin
        wr_req.en = rd_pend_q && verdict.age_write;
      end
      StFill: begin
        wr_req.en   = 1'b1;
        wr_req.addr = victim_q;
        wr_req.tag  = page_q;
        wr_req.pri  = PriFresh;
      end
      default: begin
        wr_req.en = 1'b0;
      end
    endcase
  end

  // Sequencer, result registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      page_q         <= '0;
      offset_q       <= '0;
      cnt_q          <= '0;
      rd_pend_q      <= 1'b0;
      rd_idx_q       <= '0;
      best_pri_q     <= '0;
      best_tag_q     <= '0;
      victim_q       <= '0;
      empty_found_q  <= 1'b0;
      res_kind_q     <= KindSame;
      res_slot_q     <= '0;
      res_ev_valid_q <= 1'b0;
      res_ev_page_q  <= '0;
      last_page_q    <= '0;
      last_valid_q   <= 1'b0;
      last_slot_q    <= '0;
      out_valid_q    <= 1'b0;
      out_kind_q     <= KindSame;
      out_slot_q     <= '0;
      out_offset_q   <= '0;
      out_ev_valid_q <= 1'b0;
      out_ev_page_q  <= '0;
    end else begin
      // The emit state loads the output register itself, so it is left out here.
      if (out_valid_q && !out_stall_i && (state_q != StEmit)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            page_q         <= byte_address_i[15:8];
            offset_q       <= byte_address_i[7:0];
            cnt_q          <= '0;
            rd_pend_q      <= 1'b0;
            res_ev_valid_q <= 1'b0;
            res_ev_page_q  <= '0;
            if (last_valid_q && (byte_address_i[15:8] == last_page_q)) begin
              res_kind_q <= KindSame;
              res_slot_q <= last_slot_q;
              state_q    <= StEmit;
            end else begin
              state_q <= StSearch;
            end
          end
        end

        StSearch: begin
          rd_pend_q <= issue;
          rd_idx_q  <= rd_addr;
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (rd_pend_q && verdict.hit) begin
            res_kind_q   <= KindHit;
            res_slot_q   <= rd_idx_q;
            last_page_q  <= page_q;
            last_valid_q <= 1'b1;
            last_slot_q  <= rd_idx_q;
            rd_pend_q    <= 1'b0;
            state_q      <= StEmit;
          end else if (rd_pend_q && last_idx) begin
            cnt_q         <= '0;
            rd_pend_q     <= 1'b0;
            best_pri_q    <= 9'h100;
            best_tag_q    <= '0;
            victim_q      <= '0;
            empty_found_q <= 1'b0;
            state_q       <= StAge;
          end
        end

        StAge: begin
          rd_pend_q <= issue;
          rd_idx_q  <= rd_addr;
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (rd_pend_q) begin
            // The first empty slot wins; otherwise the lowest aged priority.
            if (!empty_found_q) begin
              if (verdict.empty) begin
                empty_found_q <= 1'b1;
                victim_q      <= rd_idx_q;
              end else if (verdict.better) begin
                best_pri_q <= {1'b0, verdict.aged_pri};
                best_tag_q <= rd_entry.tag;
                victim_q   <= rd_idx_q;
              end
            end
            if (last_idx) begin
              rd_pend_q <= 1'b0;
              state_q   <= StFill;
            end
          end
        end

        StFill: begin
          res_kind_q     <= KindMiss;
          res_slot_q     <= victim_q;
          res_ev_valid_q <= !empty_found_q;
          res_ev_page_q  <= empty_found_q ? 8'h00 : best_tag_q;
          last_page_q    <= page_q;
          last_valid_q   <= 1'b1;
          last_slot_q    <= victim_q;
          state_q        <= StEmit;
        end

        StEmit: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            out_kind_q     <= res_kind_q;
            out_slot_q     <= slot_ext[5:0];
            out_offset_q   <= offset_q;
            out_ev_valid_q <= res_ev_valid_q;
            out_ev_page_q  <= res_ev_page_q;
            state_q        <= StIdle;
          end
        end

        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o      = (state_q != StIdle);
  assign out_valid_o     = out_valid_q;
  assign access_kind_o   = out_kind_q;
  assign slot_index_o    = out_slot_q;
  assign byte_offset_o   = out_offset_q;
  assign evicted_valid_o = out_ev_valid_q;
  assign evicted_page_o  = out_ev_page_q;

endmodule

`default_nettype wire
